### rtl/multilevel_priority_fifo_scheduler_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the priority FIFO scheduler
// Concurrent checks sampled on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MULTILEVEL_PRIORITY_FIFO_SCHEDULER_CORE_MACROS_SVH
`define MULTILEVEL_PRIORITY_FIFO_SCHEDULER_CORE_MACROS_SVH

// Check that a condition holds at every edge outside reset.
`define MLPFS_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// Check that a consequent holds whenever the antecedent holds.
`define MLPFS_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

### rtl/mlpfs_pkg.sv
// ----------------------------------------------------------------------------
// mlpfs_pkg
// Shared widths, command codes and beat payload types of the scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package mlpfs_pkg;

	localparam int TASK_ID_W     = 4;
	localparam int BAND_W        = 3;
	localparam int COUNT_W       = 5;
	localparam int NUM_BANDS_DEF = 8;
	localparam int MAX_TASKS_DEF = 16;

	typedef enum logic [1:0] {
		CMD_SPAWN    = 2'd0,
		CMD_YIELD    = 2'd1,
		CMD_EXIT     = 2'd2,
		CMD_SCHEDULE = 2'd3
	} command_t;

	typedef struct packed {
		command_t               command;
		logic [TASK_ID_W-1:0]   task_id;
		logic [BAND_W-1:0]      band;
	} req_t;

	typedef struct packed {
		logic                   running_valid;
		logic [TASK_ID_W-1:0]   running_task;
		logic                   switched;
		logic                   reap_valid;
		logic [TASK_ID_W-1:0]   reap_task;
		logic                   halted;
		logic [COUNT_W-1:0]     runnable_count;
	} rsp_t;

endpackage

`default_nettype wire

### rtl/mlpfs_stream_if.sv
// ----------------------------------------------------------------------------
// mlpfs_stream_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface mlpfs_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/mlpfs_ram.sv
// ----------------------------------------------------------------------------
// mlpfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mlpfs_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/multilevel_priority_fifo_scheduler_core.sv
// ----------------------------------------------------------------------------
// multilevel_priority_fifo_scheduler_core
// Multilevel priority round-robin scheduler with one linked FIFO per band.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one command beat (spawn, yield, exit, schedule) with a task
//   id and a band; rsp returns exactly one result beat per command with the
//   running task, switch and reap flags, the halt flag and the runnable count.
//   A small sequencer drives one queue update unit: it appends to a band
//   tail, then picks the highest non-empty band and dequeues its head. The
//   next-link store is a RAM with registered read, so a dequeue that leaves
//   the band non-empty passes through an extra link step to fetch the new head.
//   Each command goes from idle to an execute step; spawn and any command
//   after halt then go to done, while yield/exit/schedule go through a switch
//   step, and the link step when the new head comes from the link RAM.
//   req.ready is high only while the sequencer is idle, so one command is
//   in flight at a time.
//   The result sits in an output register; while rsp stalls the next command
//   is still taken and worked, and the sequencer holds at its last step
//   until the register frees up.
//   Reset clears all queues, the running task, the count and the halt flag.
//   Once halted, every command is ignored and reports the held state.
// ----------------------------------------------------------------------------
`default_nettype none
`include "multilevel_priority_fifo_scheduler_core_macros.svh"

module multilevel_priority_fifo_scheduler_core #(
	parameter int NUM_BANDS = mlpfs_pkg::NUM_BANDS_DEF,
	parameter int MAX_TASKS = mlpfs_pkg::MAX_TASKS_DEF
) (
	input wire logic        clk,
	input wire logic        arst_n,
	mlpfs_stream_if.sink    req,
	mlpfs_stream_if.source  rsp
);

	localparam int TW = $clog2(MAX_TASKS);
	localparam int BW = $clog2(NUM_BANDS);
	localparam int CW = $clog2(MAX_TASKS + 1);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_EXEC   = 5'b00010,
		ST_SWITCH = 5'b00100,
		ST_LINK   = 5'b01000,
		ST_DONE   = 5'b10000
	} state_t;

	state_t state_q;

	// latched command beat
	mlpfs_pkg::command_t                 cmd_q;
	logic [mlpfs_pkg::TASK_ID_W-1:0]     tid_q;
	logic [mlpfs_pkg::BAND_W-1:0]        band_q;

	// queue storage
	logic [TW-1:0]        head_q [NUM_BANDS];
	logic [TW-1:0]        tail_q [NUM_BANDS];
	logic [NUM_BANDS-1:0] nonempty_q;
	logic [MAX_TASKS-1:0] busy_q;

	// processor state
	logic [TW-1:0] cur_task_q;
	logic [BW-1:0] cur_band_q;
	logic          cur_valid_q;
	logic          cur_dead_q;
	logic          reap_pend_valid_q;
	logic [TW-1:0] reap_pend_task_q;
	logic [CW-1:0] count_q;
	logic          halt_q;

	// per-command result flags
	logic          switched_q;
	logic          reaped_q;
	logic [TW-1:0] reap_id_q;
	logic [BW-1:0] pop_band_q;

	logic             rsp_valid_q;
	mlpfs_pkg::rsp_t  rsp_data_q;

	// datapath signals
	logic          in_fire;
	logic [TW-1:0] tid_idx;
	logic [BW-1:0] spawn_band;
	logic          spawn_ok;
	logic          push_en;
	logic [TW-1:0] push_task;
	logic [BW-1:0] push_band;
	logic          pop_found;
	logic [BW-1:0] pop_band;
	logic [TW-1:0] pop_head;
	logic          pop_last;
	logic          link_we;
	logic          link_re;
	logic [TW-1:0] link_rdata;
	logic          out_free;

	assign in_fire  = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign out_free = !rsp_valid_q || rsp.ready;

	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_data_q;

	// spawn decode: range check the slot, saturate the band
	always_comb begin
		tid_idx    = TW'(tid_q);
		spawn_band = (32'(band_q) >= NUM_BANDS) ? BW'(NUM_BANDS - 1) : BW'(band_q);
		spawn_ok   = (cmd_q == mlpfs_pkg::CMD_SPAWN) && (32'(tid_q) < MAX_TASKS)
			&& !busy_q[tid_idx];
	end

	// append request for the execute step
	always_comb begin
		push_en   = 1'b0;
		push_task = tid_idx;
		push_band = spawn_band;
		if (state_q == ST_EXEC && !halt_q) begin
			if (spawn_ok) begin
				push_en = 1'b1;
			end else if (cmd_q == mlpfs_pkg::CMD_YIELD && cur_valid_q) begin
				push_en   = 1'b1;
				push_task = cur_task_q;
				push_band = cur_band_q;
			end
		end
	end

	// highest non-empty band (band 0 wins)
	always_comb begin
		pop_found = 1'b0;
		pop_band  = '0;
		for (int i = NUM_BANDS - 1; i >= 0; i--) begin
			if (nonempty_q[i]) begin
				pop_found = 1'b1;
				pop_band  = BW'(i);
			end
		end
		pop_head = head_q[pop_band];
		pop_last = (pop_head == tail_q[pop_band]);
	end

	assign link_we = push_en && nonempty_q[push_band];
	assign link_re = (state_q == ST_SWITCH) && pop_found && !pop_last;

	mlpfs_ram #(
		.WIDTH (TW),
		.DEPTH (MAX_TASKS)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (tail_q[push_band]),
		.wdata (push_task),
		.re    (link_re),
		.raddr (pop_head),
		.rdata (link_rdata)
	);

	// payload registers: command latch, head/tail pointers, result beat
	always_ff @(posedge clk) begin
		if (in_fire) begin
			cmd_q  <= req.payload.command;
			tid_q  <= req.payload.task_id;
			band_q <= req.payload.band;
		end
		if (push_en) begin
			tail_q[push_band] <= push_task;
			if (!nonempty_q[push_band]) begin
				head_q[push_band] <= push_task;
			end
		end
		if (state_q == ST_SWITCH && pop_found && !pop_last) begin
			pop_band_q <= pop_band;
		end
		if (state_q == ST_LINK) begin
			head_q[pop_band_q] <= link_rdata;
		end
		if (state_q == ST_DONE && out_free) begin
			rsp_data_q.running_valid  <= cur_valid_q;
			rsp_data_q.running_task   <= cur_valid_q ?
				mlpfs_pkg::TASK_ID_W'(cur_task_q) : '0;
			rsp_data_q.switched       <= switched_q;
			rsp_data_q.reap_valid     <= reaped_q;
			rsp_data_q.reap_task      <= reaped_q ?
				mlpfs_pkg::TASK_ID_W'(reap_id_q) : '0;
			rsp_data_q.halted         <= halt_q;
			rsp_data_q.runnable_count <= mlpfs_pkg::COUNT_W'(count_q);
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			nonempty_q        <= '0;
			busy_q            <= '0;
			cur_task_q        <= '0;
			cur_band_q        <= '0;
			cur_valid_q       <= 1'b0;
			cur_dead_q        <= 1'b0;
			reap_pend_valid_q <= 1'b0;
			reap_pend_task_q  <= '0;
			count_q           <= '0;
			halt_q            <= 1'b0;
			switched_q        <= 1'b0;
			reaped_q          <= 1'b0;
			reap_id_q         <= '0;
			rsp_valid_q       <= 1'b0;
		end else begin
			// load a new result beat, or drop the one the sink just took
			if (state_q == ST_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (push_en) begin
				nonempty_q[push_band] <= 1'b1;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						switched_q <= 1'b0;
						reaped_q   <= 1'b0;
						reap_id_q  <= '0;
						state_q    <= ST_EXEC;
					end
				end

				ST_EXEC: begin
					if (halt_q) begin
						state_q <= ST_DONE;
					end else begin
						case (cmd_q)
							mlpfs_pkg::CMD_SPAWN: begin
								if (spawn_ok) begin
									busy_q[tid_idx] <= 1'b1;
									if (count_q < CW'(MAX_TASKS)) begin
										count_q <= count_q + 1'b1;
									end
								end
								state_q <= ST_DONE;
							end
							mlpfs_pkg::CMD_EXIT: begin
								// mark the running task dead; a switch that picks a new task parks it for reaping
								if (cur_valid_q) begin
									cur_dead_q <= 1'b1;
									if (count_q != '0) begin
										count_q <= count_q - 1'b1;
									end
								end
								state_q <= ST_SWITCH;
							end
							default: begin
								state_q <= ST_SWITCH;
							end
						endcase
					end
				end

				ST_SWITCH: begin
					// free the task parked by the previous switch
					if (reap_pend_valid_q) begin
						busy_q[reap_pend_task_q] <= 1'b0;
						reaped_q                 <= 1'b1;
						reap_id_q                <= reap_pend_task_q;
					end
					// park a dead outgoing task, otherwise clear the parking slot
					if (pop_found && cur_valid_q && cur_dead_q) begin
						reap_pend_valid_q <= 1'b1;
						reap_pend_task_q  <= cur_task_q;
					end else if (reap_pend_valid_q) begin
						reap_pend_valid_q <= 1'b0;
						reap_pend_task_q  <= '0;
					end
					if (pop_found) begin
						cur_task_q  <= pop_head;
						cur_band_q  <= pop_band;
						cur_valid_q <= 1'b1;
						cur_dead_q  <= 1'b0;
						switched_q  <= 1'b1;
						if (pop_last) begin
							nonempty_q[pop_band] <= 1'b0;
							state_q              <= ST_DONE;
						end else begin
							state_q <= ST_LINK;
						end
					end else begin
						// nothing queued: keep a live task, otherwise halt for good
						if (!(cur_valid_q && !cur_dead_q)) begin
							halt_q      <= 1'b1;
							cur_valid_q <= 1'b0;
						end
						state_q <= ST_DONE;
					end
				end

				ST_LINK: begin
					state_q <= ST_DONE;
				end

				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`MLPFS_ASSERT_IMPLY(a_halt_idle_cpu, halt_q, !cur_valid_q, "halted with a running task")
	`MLPFS_ASSERT_IMPLY(a_reap_not_current, reap_pend_valid_q, cur_valid_q && (reap_pend_task_q != cur_task_q), "parked task collides with running task")
	`MLPFS_ASSERT_IMPLY(a_current_busy, cur_valid_q, busy_q[cur_task_q], "running task slot is free")
	`MLPFS_ASSERT_ALWAYS(a_count_range, count_q <= CW'(MAX_TASKS), "runnable count out of range")

endmodule

`default_nettype wire

### tb/multilevel_priority_fifo_scheduler_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multilevel_priority_fifo_scheduler_core_tb
// Self-checking bench for the priority FIFO scheduler. A short stimulus table
// exercises spawn, yield, exit and schedule around their corner cases. A long
// run of random commands follows, shaped so that the queues stay busy. The
// bench finishes by driving the block into halt. Every result beat is checked
// against a scheduler model kept inside the bench, or against the typed
// result of a table row, under phases of source idling and sink backpressure.
// ----------------------------------------------------------------------------

module multilevel_priority_fifo_scheduler_core_tb;

	import mlpfs_pkg::*;

	localparam int NB         = NUM_BANDS_DEF;
	localparam int NT         = MAX_TASKS_DEF;
	localparam int RAND_BEATS = 750;
	localparam int IDLE_LIMIT = 2000;
	localparam int LONG_HOLD  = 80;
	localparam int MAX_ORPHAN = 4;

	typedef enum logic [1:0] {
		SLOT_FREE    = 2'd0,
		SLOT_READY   = 2'd1,
		SLOT_RUNNING = 2'd2,
		SLOT_DEAD    = 2'd3
	} slot_state_t;

	typedef struct {
		command_t              cmd;
		logic [TASK_ID_W-1:0]  tid;
		logic [BAND_W-1:0]     band;
		bit                    typed;
		rsp_t                  rsp;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	mlpfs_stream_if #(.payload_t(req_t)) req_if ();
	mlpfs_stream_if #(.payload_t(rsp_t)) rsp_if ();

	multilevel_priority_fifo_scheduler_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Scheduler model: per-band linked FIFOs, slot states, running task.
	// ------------------------------------------------------------------------
	logic [TASK_ID_W-1:0] q_head [NB];
	logic [TASK_ID_W-1:0] q_tail [NB];
	logic [NB-1:0]        band_busy = '0;
	logic [TASK_ID_W-1:0] link_next [NT];
	logic [BAND_W-1:0]    slot_band [NT];
	slot_state_t          slot_state [NT];
	logic [TASK_ID_W-1:0] cur_task  = '0;
	logic                 cur_valid = 1'b0;
	logic                 reap_held = 1'b0;
	logic [TASK_ID_W-1:0] reap_slot = '0;
	logic [COUNT_W-1:0]   run_total = '0;
	logic                 halt_seen = 1'b0;

	initial begin
		foreach (slot_state[i])
			slot_state[i] = SLOT_FREE;
	end

	// Append a slot at the tail of its band and mark it ready.
	function automatic void enqueue_slot(logic [TASK_ID_W-1:0] t);
		logic [BAND_W-1:0] b;
		b = slot_band[t];
		slot_state[t] = SLOT_READY;
		if (band_busy[b]) begin
			link_next[q_tail[b]] = t;
			q_tail[b] = t;
		end else begin
			q_head[b] = t;
			q_tail[b] = t;
			band_busy[b] = 1'b1;
		end
	endfunction

	// Take the head of the highest non-empty band.
	function automatic bit dequeue_top(output logic [TASK_ID_W-1:0] t);
		t = '0;
		for (int b = 0; b < NB; b++) begin
			if (band_busy[b]) begin
				t = q_head[b];
				if (t == q_tail[b])
					band_busy[b] = 1'b0;
				else
					q_head[b] = link_next[t];
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	// Free the held dead slot, then pick the next task or keep / halt.
	function automatic void switch_task(inout rsp_t r);
		logic [TASK_ID_W-1:0] nxt;
		logic                 had_cur;
		logic [TASK_ID_W-1:0] prev;
		had_cur = cur_valid;
		prev    = cur_task;
		if (reap_held) begin
			slot_state[reap_slot] = SLOT_FREE;
			r.reap_valid = 1'b1;
			r.reap_task  = reap_slot;
			reap_held    = 1'b0;
			reap_slot    = '0;
		end
		if (!dequeue_top(nxt)) begin
			if (!(had_cur && slot_state[prev] == SLOT_RUNNING)) begin
				halt_seen = 1'b1;
				cur_valid = 1'b0;
			end
			return;
		end
		if (had_cur && slot_state[prev] == SLOT_DEAD) begin
			reap_held = 1'b1;
			reap_slot = prev;
		end
		slot_state[nxt] = SLOT_RUNNING;
		cur_task   = nxt;
		cur_valid  = 1'b1;
		r.switched = 1'b1;
	endfunction

	function automatic rsp_t predict_schedule(req_t c);
		rsp_t r;
		r = '0;
		if (!halt_seen) begin
			case (c.command)
				CMD_SPAWN: begin
					if (slot_state[c.task_id] == SLOT_FREE) begin
						slot_band[c.task_id] = (int'(c.band) > NB - 1) ? BAND_W'(NB - 1) : c.band;
						enqueue_slot(c.task_id);
						if (run_total < NT)
							run_total++;
					end
				end
				CMD_YIELD: begin
					if (cur_valid && slot_state[cur_task] == SLOT_RUNNING)
						enqueue_slot(cur_task);
					switch_task(r);
				end
				CMD_EXIT: begin
					if (cur_valid) begin
						slot_state[cur_task] = SLOT_DEAD;
						if (run_total > 0)
							run_total--;
					end
					switch_task(r);
				end
				default: begin
					switch_task(r);
				end
			endcase
		end
		r.running_valid  = cur_valid;
		r.running_task   = cur_valid ? cur_task : '0;
		r.halted         = halt_seen;
		r.runnable_count = run_total;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Random command shaping
	// ------------------------------------------------------------------------
	int orphans = 0;

	// Mostly pick a free slot so that spawns take effect; sometimes any slot.
	function automatic logic [TASK_ID_W-1:0] pick_slot();
		logic [TASK_ID_W-1:0] s;
		s = TASK_ID_W'($urandom_range(NT - 1));
		if ($urandom_range(3) != 0) begin
			for (int i = 0; i < NT; i++) begin
				if (slot_state[(int'(s) + i) % NT] == SLOT_FREE)
					return TASK_ID_W'((int'(s) + i) % NT);
			end
		end
		return s;
	endfunction

	// True when this command would find nothing runnable and halt the block.
	function automatic bit would_halt(command_t c);
		if (c == CMD_SPAWN || band_busy != '0)
			return 1'b0;
		if (c == CMD_EXIT)
			return 1'b1;
		return !(cur_valid && slot_state[cur_task] == SLOT_RUNNING);
	endfunction

	function automatic req_t pick_command();
		req_t c;
		int   roll;
		c.task_id = pick_slot();
		c.band    = BAND_W'($urandom_range((1 << BAND_W) - 1));
		roll      = $urandom_range(99);
		if (roll < 35)
			c.command = CMD_SPAWN;
		else if (roll < 62)
			c.command = CMD_YIELD;
		else if (roll < 88)
			c.command = CMD_EXIT;
		else
			c.command = CMD_SCHEDULE;
		// keep halt for the closing sequence: reset comes only once
		if (would_halt(c.command))
			c.command = CMD_SPAWN;
		// schedule with a ready queue drops the running slot for good; ration it
		if (c.command == CMD_SCHEDULE && band_busy != '0 && cur_valid) begin
			if (orphans >= MAX_ORPHAN)
				c.command = CMD_YIELD;
			else
				orphans++;
		end
		return c;
	endfunction

	// ------------------------------------------------------------------------
	// Expected results and statistics
	// ------------------------------------------------------------------------
	rsp_t pending_results [$];
	int   mismatches   = 0;
	int   cmd_seen [4] = '{default: 0};
	int   ignored      = 0;
	int   effective    = 0;
	int   switches     = 0;
	int   reaps        = 0;
	int   idle_pct     = 0;
	int   stall_pct    = 0;
	bit   hold_req     = 1'b0;

	function automatic rsp_t mk_rsp(bit rv, int rt, bit sw, bit rp, int rpt, bit h, int cnt);
		rsp_t r;
		r.running_valid  = rv;
		r.running_task   = TASK_ID_W'(rt);
		r.switched       = sw;
		r.reap_valid     = rp;
		r.reap_task      = TASK_ID_W'(rpt);
		r.halted         = h;
		r.runnable_count = COUNT_W'(cnt);
		return r;
	endfunction

	function automatic void report_bad(string what, rsp_t want, rsp_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t: %s", $realtime, what);
			$display("  want rv=%0d rt=%0d sw=%0d rp=%0d rpt=%0d h=%0d cnt=%0d",
				want.running_valid, want.running_task, want.switched, want.reap_valid,
				want.reap_task, want.halted, want.runnable_count);
			$display("  got  rv=%0d rt=%0d sw=%0d rp=%0d rpt=%0d h=%0d cnt=%0d",
				got.running_valid, got.running_task, got.switched, got.reap_valid,
				got.reap_task, got.halted, got.runnable_count);
		end
	endfunction

	// Offer one command beat, with a random gap ahead of it, and predict its
	// result once the block takes it. A typed row overrides the prediction.
	task automatic send_cmd(req_t c, bit typed, rsp_t typed_rsp);
		rsp_t r;
		bit   takes;
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid   <= 1'b1;
		req_if.payload <= c;
		do
			@(posedge clk);
		while (!(req_if.valid && req_if.ready));
		takes = !(halt_seen || (c.command == CMD_SPAWN && slot_state[c.task_id] != SLOT_FREE));
		r = predict_schedule(c);
		pending_results.push_back(typed ? typed_rsp : r);
		cmd_seen[c.command]++;
		if (takes)
			effective++;
		else
			ignored++;
		if (r.switched)
			switches++;
		if (r.reap_valid)
			reaps++;
	endtask

	// ------------------------------------------------------------------------
	// Result sink: random stalls plus one long hold-off on request.
	// ------------------------------------------------------------------------
	initial begin
		int  hold_left;
		bit  hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		rsp_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				hold_left = LONG_HOLD;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_if.ready <= 1'b0;
			end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
				rsp_if.ready <= 1'b0;
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	// Compare each result beat with the oldest expectation.
	always @(posedge clk) begin
		rsp_t want;
		rsp_t got;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got = rsp_if.payload;
			if (pending_results.size() == 0) begin
				report_bad("result beat with nothing expected", '0, got);
			end else begin
				want = pending_results.pop_front();
				if (got.running_valid !== want.running_valid ||
					got.running_task !== want.running_task ||
					got.switched !== want.switched ||
					got.reap_valid !== want.reap_valid ||
					got.reap_task !== want.reap_task ||
					got.halted !== want.halted ||
					got.runnable_count !== want.runnable_count)
					report_bad("result beat mismatch", want, got);
			end
		end
	end

	// Watchdog: end the run when no beat moves on either side for too long.
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no beat moved for %0d cycles", IDLE_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	dir_row_t dir_tab [$];

	function automatic void add_row(command_t cmd, int tid, int band, bit typed, rsp_t rsp);
		dir_row_t row;
		row.cmd   = cmd;
		row.tid   = TASK_ID_W'(tid);
		row.band  = BAND_W'(band);
		row.typed = typed;
		row.rsp   = rsp;
		dir_tab.push_back(row);
	endfunction

	initial begin
		req_t c;
		int   phase;
		arst_n         <= 1'b0;
		req_if.valid   <= 1'b0;
		req_if.payload <= '0;

		// Corner cases: top slot and bottom band, busy slot, exit with nothing
		// running, same-band FIFO order, reap after exit, keep on an empty
		// queue, yield with only itself to pick.
		add_row(CMD_SPAWN,    15, 7, 1'b1, mk_rsp(0, 0, 0, 0, 0, 0, 1));
		add_row(CMD_SPAWN,     0, 0, 1'b1, mk_rsp(0, 0, 0, 0, 0, 0, 2));
		add_row(CMD_SPAWN,    15, 3, 1'b1, mk_rsp(0, 0, 0, 0, 0, 0, 2));
		add_row(CMD_EXIT,     15, 7, 1'b1, mk_rsp(1, 0, 1, 0, 0, 0, 2));
		add_row(CMD_SPAWN,     5, 2, 1'b0, '0);
		add_row(CMD_SPAWN,     6, 2, 1'b0, '0);
		add_row(CMD_YIELD,     0, 0, 1'b0, '0);
		add_row(CMD_EXIT,     10, 5, 1'b0, '0);
		add_row(CMD_SCHEDULE,  3, 1, 1'b0, '0);
		add_row(CMD_SPAWN,     9, 4, 1'b0, '0);
		add_row(CMD_YIELD,    12, 6, 1'b0, '0);
		add_row(CMD_EXIT,      7, 3, 1'b0, '0);
		add_row(CMD_EXIT,      0, 0, 1'b0, '0);
		add_row(CMD_SCHEDULE, 15, 7, 1'b0, '0);
		add_row(CMD_YIELD,     0, 0, 1'b0, '0);
		add_row(CMD_SPAWN,    10, 1, 1'b0, '0);
		add_row(CMD_SPAWN,     3, 6, 1'b0, '0);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			c.command = dir_tab[i].cmd;
			c.task_id = dir_tab[i].tid;
			c.band    = dir_tab[i].band;
			send_cmd(c, dir_tab[i].typed, dir_tab[i].rsp);
		end

		// Random part in five phases: clean, source idle, sink stall with one
		// long hold-off (the source keeps offering), both, clean again.
		effective = 0;
		while (effective < RAND_BEATS) begin
			phase = effective * 5 / RAND_BEATS;
			case (phase)
				1: begin
					idle_pct  = 62;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 62;
					hold_req  = 1'b1;
				end
				3: begin
					idle_pct  = 25;
					stall_pct = 25;
				end
				default: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
			endcase
			send_cmd(pick_command(), 1'b0, '0);
		end

		// Close out: exit tasks until nothing is runnable, then show that
		// the halted block ignores every command.
		idle_pct  = 25;
		stall_pct = 25;
		while (!halt_seen) begin
			c.command = CMD_EXIT;
			c.task_id = TASK_ID_W'($urandom_range(NT - 1));
			c.band    = BAND_W'($urandom_range((1 << BAND_W) - 1));
			send_cmd(c, 1'b0, '0);
		end
		c = '{command: CMD_SPAWN, task_id: '0, band: '0};
		send_cmd(c, 1'b0, '0);
		c.command = CMD_YIELD;
		send_cmd(c, 1'b0, '0);
		c.command = CMD_SCHEDULE;
		send_cmd(c, 1'b0, '0);
		req_if.valid <= 1'b0;

		// Drain, then give the block time to emit anything unexpected.
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Ran %0d commands: %0d spawn, %0d yield, %0d exit, %0d schedule (%0d ignored).",
			cmd_seen[CMD_SPAWN] + cmd_seen[CMD_YIELD] + cmd_seen[CMD_EXIT] +
			cmd_seen[CMD_SCHEDULE], cmd_seen[CMD_SPAWN], cmd_seen[CMD_YIELD],
			cmd_seen[CMD_EXIT], cmd_seen[CMD_SCHEDULE], ignored);
		$display("Saw %0d switches, %0d reaps, halt reached: %0d, mismatches: %0d.",
			switches, reaps, halt_seen, mismatches);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### files.f
+incdir+rtl
rtl/mlpfs_pkg.sv
rtl/mlpfs_stream_if.sv
rtl/mlpfs_ram.sv
rtl/multilevel_priority_fifo_scheduler_core.sv
tb/multilevel_priority_fifo_scheduler_core_tb.sv
